@@ src/sra_pkg.sv @@
// shared types, constants and helpers for the skyline rectangle allocator
package sra_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NO_ROOM = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic OP_CLEAR = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    localparam logic [7:0] CFG_ATLAS_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_ATLAS_HEIGHT = 8'd1;

    localparam logic [12:0] ATLAS_RESET = 13'd512;
    localparam logic [12:0] SIZE_MIN    = 13'd3;
    localparam logic [12:0] SIZE_MAX    = 13'd4096;

    typedef struct packed {
        logic        operation;
        logic [12:0] req_width;
        logic [12:0] req_height;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] place_x;
        logic [11:0] place_y;
    } res_t;

    typedef struct packed {
        logic [11:0] x;
        logic [12:0] top;
        logic [12:0] width;
    } seg_t;

    // controller to datapath
    typedef struct packed {
        logic       accept;
        logic       init;
        logic       clear;
        logic       res_set;
        logic [1:0] res_code;
        logic       search_start;
        logic       rd_walk;
        logic       eval;
        logic       pass_start;
        logic       rd_pass;
        logic       inject;
        logic       pass_ev;
        logic       flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_alloc;
        logic w_zero;
        logic ev_end;
        logic ev_last;
        logic found;
        logic full;
        logic r_is_best;
        logic pass_last;
    } stat_t;

    function automatic logic [12:0] clamp_size(input logic [12:0] v);
        if (v < SIZE_MIN) begin
            return SIZE_MIN;
        end else if (v > SIZE_MAX) begin
            return SIZE_MAX;
        end
        return v;
    endfunction

endpackage

@@ src/skyline_rect_allocator.sv @@
// top level of the skyline rectangle allocator
//
//  channel  ports                               direction  moves
//  s        s_valid s_ready s_data (req_t)      in         one request: clear or allocate
//  m        m_valid m_ready m_data (res_t)      out        one result per request
//  cfg      cfg_valid cfg_ready cfg_index/data  in         atlas width / height writes
//
//  a request passes through decode, the fit search and, after a placement, the table rebuild
//  fit search: a read and an evaluate step per entry walked, since the segment memory
//  has a single read port
//  rebuild after a placement: a read and an evaluate step per segment, plus an inject step
//  for the new segment; the last table write overlaps the result cycle
//  reset: the init state writes the border segment before the first request is taken
//  a result waiting on m does not block acceptance of the next request
module skyline_rect_allocator (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sra_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output sra_pkg::res_t m_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [12:0]   cfg_data
);

    // configuration registers, raw as written
    logic [12:0] atlas_width_reg, atlas_height_reg;
    logic [12:0] aw, ah;

    // output register
    logic          m_valid_reg;
    sra_pkg::res_t m_data_reg;

    sra_pkg::cmd_t  cmd;
    sra_pkg::stat_t st;
    sra_pkg::res_t  dp_result;
    logic           res_load;
    logic           out_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_width_reg  <= sra_pkg::ATLAS_RESET;
            atlas_height_reg <= sra_pkg::ATLAS_RESET;
        end else if (cfg_valid) begin
            // unknown indexes are dropped
            if (cfg_index == sra_pkg::CFG_ATLAS_WIDTH) begin
                atlas_width_reg <= cfg_data;
            end else if (cfg_index == sra_pkg::CFG_ATLAS_HEIGHT) begin
                atlas_height_reg <= cfg_data;
            end
        end
    end

    // out of range sizes act as the nearest legal size
    assign aw = sra_pkg::clamp_size(atlas_width_reg);
    assign ah = sra_pkg::clamp_size(atlas_height_reg);

    // result slot is free when it is empty or when the held result is taken this cycle
    assign out_free = !m_valid_reg || m_ready;

    sra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (out_free),
        .res_load (res_load),
        .st       (st),
        .cmd      (cmd)
    );

    sra_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .aw      (aw),
        .ah      (ah),
        .st      (st),
        .result  (dp_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_data_reg <= dp_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/sra_ctrl.sv @@
// sequencing state machine of the skyline allocator
module sra_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           out_free,
    output logic           res_load,
    input  sra_pkg::stat_t st,
    output sra_pkg::cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_INIT   = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_DECODE = 10'b0000000100,
        S_WRD    = 10'b0000001000,
        S_WEV    = 10'b0000010000,
        S_SEL    = 10'b0000100000,
        S_PRD    = 10'b0001000000,
        S_PINJ   = 10'b0010000000,
        S_PEV    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        res_load   = 1'b0;
        unique case (state_reg)
            S_INIT: begin
                cmd.init   = 1'b1;
                state_next = S_IDLE;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!st.op_alloc) begin
                    cmd.clear    = 1'b1;
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sra_pkg::ST_PLACED;
                    state_next   = S_DONE;
                end else if (st.w_zero) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sra_pkg::ST_NO_ROOM;
                    state_next   = S_DONE;
                end else begin
                    cmd.search_start = 1'b1;
                    state_next       = S_WRD;
                end
            end
            S_WRD: begin
                cmd.rd_walk = 1'b1;
                state_next  = S_WEV;
            end
            S_WEV: begin
                cmd.eval   = 1'b1;
                state_next = (st.ev_end && st.ev_last) ? S_SEL : S_WRD;
            end
            S_SEL: begin
                if (!st.found) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sra_pkg::ST_NO_ROOM;
                    state_next   = S_DONE;
                end else if (st.full) begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sra_pkg::ST_FULL;
                    state_next   = S_DONE;
                end else begin
                    cmd.pass_start = 1'b1;
                    state_next     = S_PRD;
                end
            end
            S_PRD: begin
                cmd.rd_pass = 1'b1;
                state_next  = st.r_is_best ? S_PINJ : S_PEV;
            end
            S_PINJ: begin
                cmd.inject = 1'b1;
                state_next = S_PEV;
            end
            S_PEV: begin
                cmd.pass_ev = 1'b1;
                if (st.pass_last) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_PRD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
        // final write of the held segment happens on the last pass step's exit
        cmd.flush = (state_reg == S_PEV) && st.pass_last;
    end

endmodule

@@ src/sra_dp.sv @@
// segment table, fit search and rebuild datapath
module sra_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sra_pkg::cmd_t          cmd,
    input  sra_pkg::req_t          s_data,
    input  logic [12:0]            aw,
    input  logic [12:0]            ah,
    output sra_pkg::stat_t         st,
    output sra_pkg::res_t          result
);

    localparam int AW = sra_pkg::SEG_AW;
    localparam int CW = sra_pkg::CNT_W;

    sra_pkg::seg_t mem [sra_pkg::MAX_SEGMENTS];
    sra_pkg::seg_t rd_q;

    sra_pkg::req_t req_reg;
    sra_pkg::res_t res_reg;
    logic [CW-1:0] count_reg;

    // search state
    logic [CW-1:0] s_reg, i_reg;
    logic [12:0]   y_reg;
    logic signed [14:0] left_reg;
    logic [12:0]   stw_reg;
    logic [11:0]   stx_reg;
    logic          found_reg;
    logic [AW-1:0] best_reg;
    logic [13:0]   besth_reg;
    logic [12:0]   bestw_reg;
    logic [11:0]   bx_reg;
    logic [12:0]   by_reg;

    // rebuild state
    logic [CW-1:0] r_reg;
    logic [AW-1:0] wp_reg;
    sra_pkg::seg_t cur_reg;
    logic          cur_v_reg;
    logic          trim_reg;
    // second write of a two-write flush
    logic          flush2_reg;

    logic [12:0] w, h;
    assign w = req_reg.req_width;
    assign h = req_reg.req_height;

    // walk step
    logic               first;
    logic [12:0]        y_base, y_n, stw_n;
    logic [11:0]        stx_n;
    logic signed [14:0] left_base, left_n;
    logic               xfail, hfail, ev_fail, ev_ok, ev_end;
    logic [13:0]        cand;
    logic               better;

    always_comb begin
        first     = (i_reg == s_reg);
        y_base    = first ? rd_q.top : y_reg;
        left_base = first ? $signed({2'b00, w}) : left_reg;
        stw_n     = first ? rd_q.width : stw_reg;
        stx_n     = first ? rd_q.x : stx_reg;
        xfail     = first && (({2'b00, rd_q.x} + {1'b0, w}) > ({1'b0, aw} - 14'd1));
        y_n       = (rd_q.top > y_base) ? rd_q.top : y_base;
        cand      = {1'b0, y_n} + {1'b0, h};
        hfail     = cand > ({1'b0, ah} - 14'd1);
        left_n    = left_base - $signed({2'b00, rd_q.width});
        ev_ok     = !xfail && !hfail && (left_n <= 15'sd0);
        ev_fail   = xfail || hfail || ((left_n > 15'sd0) && ((i_reg + 1'b1) >= count_reg));
        ev_end    = ev_ok || ev_fail;
        better    = !found_reg || (cand < besth_reg) ||
                    ((cand == besth_reg) && (stw_n < bestw_reg));
    end

    // rebuild: incoming segment after trimming
    logic [13:0]        pe, sx14;
    logic signed [14:0] nw;
    sra_pkg::seg_t      arr, new_seg;
    logic               arr_v;
    logic               step, merge;

    always_comb begin
        pe          = {2'b00, bx_reg} + {1'b0, w};
        sx14        = {2'b00, rd_q.x};
        nw          = $signed({2'b00, rd_q.width}) - $signed({1'b0, pe - sx14});
        new_seg.x     = bx_reg;
        new_seg.top   = by_reg + h;
        new_seg.width = w;
        arr   = rd_q;
        arr_v = 1'b1;
        if (cmd.inject) begin
            arr = new_seg;
        end else if (trim_reg && (sx14 < pe)) begin
            if (nw <= 15'sd0) begin
                arr_v = 1'b0;
            end else begin
                arr.x     = pe[11:0];
                arr.width = nw[12:0];
            end
        end
        step  = (cmd.inject || cmd.pass_ev) && arr_v;
        merge = cur_v_reg && (arr.top == cur_reg.top);
    end

    // memory ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    sra_pkg::seg_t wr_data;
    logic [AW-1:0] rd_addr;

    always_comb begin
        wr_en   = cmd.init || cmd.clear || (step && cur_v_reg && !merge) || cmd.flush ||
                  flush2_reg;
        wr_addr = (cmd.init || cmd.clear) ? '0 : wp_reg;
        wr_data = cur_reg;
        if (cmd.init) begin
            wr_data = '{x: 12'd1, top: 13'd1, width: sra_pkg::ATLAS_RESET - 13'd2};
        end else if (cmd.clear) begin
            wr_data = '{x: 12'd1, top: 13'd1, width: aw - 13'd2};
        end else if (cmd.flush && step && cur_v_reg && merge) begin
            wr_data.width = cur_reg.width + arr.width;
        end
        rd_addr = cmd.rd_walk ? i_reg[AW-1:0] : r_reg[AW-1:0];
    end

    // on the final step a non-merging arrival writes the held segment first,
    // so the arrival lands at the following slot in the next cycle
    logic          flush_two;
    assign flush_two = cmd.flush && step && cur_v_reg && !merge;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_walk || cmd.rd_pass) begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CW'(1);
            found_reg <= 1'b0;
            cur_v_reg <= 1'b0;
            trim_reg  <= 1'b0;
            flush2_reg <= 1'b0;
        end else begin
            flush2_reg <= flush_two;
            if (flush2_reg) begin
                count_reg <= CW'(wp_reg) + CW'(1);
            end
            if (cmd.clear) begin
                count_reg <= CW'(1);
            end
            if (cmd.search_start) begin
                found_reg <= 1'b0;
            end
            if (cmd.eval && ev_ok && better) begin
                found_reg <= 1'b1;
            end
            if (cmd.pass_start) begin
                cur_v_reg <= 1'b0;
                trim_reg  <= 1'b0;
            end
            if (step) begin
                cur_v_reg <= 1'b1;
            end
            if (cmd.inject) begin
                trim_reg <= 1'b1;
            end else if (cmd.pass_ev && arr_v) begin
                trim_reg <= 1'b0;
            end
            if (cmd.flush && !flush_two) begin
                count_reg <= CW'(wp_reg) + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            req_reg <= s_data;
        end
        if (cmd.search_start) begin
            s_reg <= '0;
            i_reg <= '0;
        end
        if (cmd.eval) begin
            if (ev_end) begin
                s_reg <= s_reg + 1'b1;
                i_reg <= s_reg + 1'b1;
            end else begin
                i_reg    <= i_reg + 1'b1;
                y_reg    <= y_n;
                left_reg <= left_n;
                stw_reg  <= stw_n;
                stx_reg  <= stx_n;
            end
            if (ev_ok && better) begin
                best_reg  <= s_reg[AW-1:0];
                besth_reg <= cand;
                bestw_reg <= stw_n;
                bx_reg    <= stx_n;
                by_reg    <= y_n;
            end
        end
        if (cmd.pass_start) begin
            r_reg  <= '0;
            wp_reg <= '0;
        end
        if (cmd.pass_ev) begin
            r_reg <= r_reg + 1'b1;
        end
        if (step) begin
            if (!cur_v_reg) begin
                cur_reg <= arr;
            end else if (merge) begin
                cur_reg.width <= cur_reg.width + arr.width;
            end else begin
                cur_reg <= arr;
                wp_reg  <= wp_reg + 1'b1;
            end
        end
        if (cmd.res_set) begin
            res_reg <= '{status: cmd.res_code, place_x: 12'd0, place_y: 12'd0};
        end
        if (cmd.flush) begin
            res_reg <= '{status: sra_pkg::ST_PLACED, place_x: bx_reg, place_y: by_reg[11:0]};
        end
    end

    always_comb begin
        st.op_alloc  = (req_reg.operation == sra_pkg::OP_ALLOC);
        st.w_zero    = (w == 13'd0);
        st.ev_end    = ev_end;
        st.ev_last   = (s_reg + 1'b1) >= count_reg;
        st.found     = found_reg;
        st.full      = count_reg >= CW'(sra_pkg::MAX_SEGMENTS);
        st.r_is_best = (r_reg[AW-1:0] == best_reg);
        st.pass_last = (r_reg + 1'b1) == count_reg;
    end

    assign result = res_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) && (count_reg <= CW'(sra_pkg::MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_write_behind_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pass_ev || cmd.inject) |-> (CW'(wp_reg) <= r_reg))
        else $error("rebuild write pointer passed read pointer");

    a_spot_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pass_start |-> (({1'b0, by_reg} + {1'b0, h}) <= ({1'b0, ah} - 14'd1)))
        else $error("chosen spot exceeds atlas height");

endmodule
